>>> design/swsr_pkg.sv
// Shared types, constants and reset values for the single-wire sensor reader.
package swsr_pkg;

    // Frame and counter geometry
    localparam int FRAME_BITS        = 40;
    localparam int BIT_W             = $clog2(FRAME_BITS + 1);
    localparam int COUNT_WIDTH_DEF   = 16;
    localparam int READING_W         = 32;

    // Configuration port
    localparam int CFG_W             = 16;
    localparam int CFG_IDX_W         = 8;
    localparam int NUM_CFG           = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_WAIT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = CFG_IDX_W'(3);

    localparam logic [CFG_W-1:0] START_LOW_RST    = CFG_W'(2000);
    localparam logic [CFG_W-1:0] RELEASE_WAIT_RST = CFG_W'(42);
    localparam logic [CFG_W-1:0] SAMPLE_DELAY_RST = CFG_W'(30);
    localparam logic [CFG_W-1:0] TIMEOUT_RST      = CFG_W'(1000);

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START     = 3'd1,
        PH_RELEASE   = 3'd2,
        PH_RESP_LOW  = 3'd3,
        PH_RESP_HIGH = 3'd4,
        PH_BIT_LOW   = 3'd5,
        PH_BIT_SAMPLE = 3'd6,
        PH_BIT_HIGH  = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_STUCK_LOW  = 2'd1,
        ST_STUCK_HIGH = 2'd2,
        ST_CHECKSUM   = 2'd3
    } status_t;

    typedef struct packed {
        logic                 drive_low;
        logic                 busy_res;
        logic                 done_res;
        status_t              status;
        logic [READING_W-1:0] reading;
    } result_t;

endpackage

>>> design/swsr_if.sv
// Channel interfaces: tick input, result output and configuration write.
interface swsr_tick_if;
    logic valid;
    logic ready;
    logic start_request;
    logic line_level;

    modport source (output valid, output start_request, output line_level, input ready);
    modport sink   (input valid, input start_request, input line_level, output ready);
endinterface

interface swsr_result_if;
    logic        valid;
    logic        ready;
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [31:0] reading;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output status, output reading, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input status, input reading, output ready);
endinterface

interface swsr_cfg_if
    import swsr_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/swsr_cfg.sv
// Configuration register file with limits clamped to the tick counter width.
module swsr_cfg
    import swsr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [CFG_IDX_W-1:0]                wr_index,
    input  logic [CFG_W-1:0]                    wr_data,
    output logic [NUM_CFG-1:0][COUNT_WIDTH-1:0] limit
);

    logic [NUM_CFG-1:0][CFG_W-1:0] cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[CFG_START_LOW[1:0]]    <= START_LOW_RST;
            cfg_reg[CFG_RELEASE_WAIT[1:0]] <= RELEASE_WAIT_RST;
            cfg_reg[CFG_SAMPLE_DELAY[1:0]] <= SAMPLE_DELAY_RST;
            cfg_reg[CFG_TIMEOUT[1:0]]      <= TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_START_LOW:    cfg_reg[CFG_START_LOW[1:0]]    <= wr_data;
                CFG_RELEASE_WAIT: cfg_reg[CFG_RELEASE_WAIT[1:0]] <= wr_data;
                CFG_SAMPLE_DELAY: cfg_reg[CFG_SAMPLE_DELAY[1:0]] <= wr_data;
                CFG_TIMEOUT:      cfg_reg[CFG_TIMEOUT[1:0]]      <= wr_data;
                default:          ; // drop writes to unknown registers
            endcase
        end
    end

    // Clamp each register to what the tick counter can reach
    for (genvar i = 0; i < NUM_CFG; i++)
    begin : g_limit
        if (COUNT_WIDTH >= CFG_W)
        begin : g_wide
            assign limit[i] = COUNT_WIDTH'(cfg_reg[i]);
        end
        else
        begin : g_narrow
            assign limit[i] = (|cfg_reg[i][CFG_W-1:COUNT_WIDTH]) ? '1
                                                                 : cfg_reg[i][COUNT_WIDTH-1:0];
        end
    end

endmodule

>>> design/swsr_core.sv
// Transfer state machine: advances one tick per accepted input transaction.
module swsr_core
    import swsr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step_en,
    input  logic                                start_request,
    input  logic                                line_level,
    input  logic [NUM_CFG-1:0][COUNT_WIDTH-1:0] limit,
    output result_t                             res_next
);

    phase_t                  phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]  cnt_reg, cnt_next, cnt_inc;
    logic [BIT_W-1:0]        bit_reg, bit_next, bit_inc;
    logic [FRAME_BITS-1:0]   frame_reg, frame_next, shifted, end_frame;
    status_t                 status_reg, status_next, fin_status;
    logic [READING_W-1:0]    reading_reg, reading_next, fin_reading;
    logic [7:0]              sum8;
    logic                    fin;
    logic                    wait_due;
    logic [COUNT_WIDTH-1:0]  start_lim, rel_lim, smp_lim, to_lim;

    assign start_lim = limit[CFG_START_LOW[1:0]];
    assign rel_lim   = limit[CFG_RELEASE_WAIT[1:0]];
    assign smp_lim   = limit[CFG_SAMPLE_DELAY[1:0]];
    assign to_lim    = limit[CFG_TIMEOUT[1:0]];

    assign cnt_inc   = (cnt_reg != '1) ? cnt_reg + 1'b1 : cnt_reg;
    assign bit_inc   = bit_reg + 1'b1;
    assign shifted   = {frame_reg[FRAME_BITS-2:0], line_level};
    assign end_frame = (phase_reg == PH_BIT_SAMPLE) ? shifted : frame_reg;
    assign sum8      = end_frame[39:32] + end_frame[31:24] + end_frame[23:16] + end_frame[15:8];
    // A fresh level wait starts at one tick; due at once when the timeout is one or less
    assign wait_due  = (to_lim <= COUNT_WIDTH'(1));

    // Next state
    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        bit_next     = bit_reg;
        frame_next   = frame_reg;
        fin          = 1'b0;
        fin_status   = ST_OK;
        fin_reading  = '0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start_request)
                begin
                    phase_next = PH_START;
                    cnt_next   = COUNT_WIDTH'(1);
                    bit_next   = '0;
                    frame_next = '0;
                end
            end
            PH_START:
            begin
                if (cnt_reg >= start_lim)
                begin
                    phase_next = PH_RELEASE;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_inc;
            end
            PH_RELEASE:
            begin
                if (cnt_reg >= rel_lim)
                begin
                    cnt_next   = COUNT_WIDTH'(1);
                    phase_next = line_level ? PH_RESP_HIGH : PH_RESP_LOW;
                    fin        = wait_due;
                    fin_status = line_level ? ST_STUCK_HIGH : ST_STUCK_LOW;
                end
                else
                    cnt_next = cnt_inc;
            end
            PH_RESP_LOW:
            begin
                if (!line_level)
                begin
                    cnt_next   = cnt_inc;
                    fin        = (cnt_inc >= to_lim);
                    fin_status = ST_STUCK_LOW;
                end
                else
                begin
                    phase_next = PH_RESP_HIGH;
                    cnt_next   = COUNT_WIDTH'(1);
                    fin        = wait_due;
                    fin_status = ST_STUCK_HIGH;
                end
            end
            PH_RESP_HIGH:
            begin
                if (line_level)
                begin
                    cnt_next   = cnt_inc;
                    fin        = (cnt_inc >= to_lim);
                    fin_status = ST_STUCK_HIGH;
                end
                else
                begin
                    phase_next = PH_BIT_LOW;
                    cnt_next   = COUNT_WIDTH'(1);
                    fin        = wait_due;
                    fin_status = ST_STUCK_LOW;
                end
            end
            PH_BIT_LOW:
            begin
                if (!line_level)
                begin
                    cnt_next   = cnt_inc;
                    fin        = (cnt_inc >= to_lim);
                    fin_status = ST_STUCK_LOW;
                end
                else
                begin
                    phase_next = PH_BIT_SAMPLE;
                    cnt_next   = '0;
                end
            end
            PH_BIT_SAMPLE, PH_BIT_HIGH:
            begin
                if (phase_reg == PH_BIT_SAMPLE)
                    cnt_next = cnt_inc;
                if (phase_reg == PH_BIT_SAMPLE && cnt_inc < smp_lim)
                begin
                    // hold until the sample point
                end
                else if (phase_reg == PH_BIT_SAMPLE && line_level)
                begin
                    frame_next = shifted;
                    phase_next = PH_BIT_HIGH;
                    cnt_next   = COUNT_WIDTH'(1);
                    fin        = wait_due;
                    fin_status = ST_STUCK_HIGH;
                end
                else if (phase_reg == PH_BIT_HIGH && line_level)
                begin
                    cnt_next   = cnt_inc;
                    fin        = (cnt_inc >= to_lim);
                    fin_status = ST_STUCK_HIGH;
                end
                else
                begin
                    // falling edge, or a zero sample: close the bit
                    frame_next = end_frame;
                    bit_next   = bit_inc;
                    if (bit_inc >= BIT_W'(FRAME_BITS))
                    begin
                        fin = 1'b1;
                        if (sum8 == end_frame[7:0])
                        begin
                            fin_status  = ST_OK;
                            fin_reading = end_frame[FRAME_BITS-1:8];
                        end
                        else
                            fin_status = ST_CHECKSUM;
                    end
                    else
                    begin
                        phase_next = PH_BIT_LOW;
                        cnt_next   = COUNT_WIDTH'(1);
                        fin        = wait_due;
                        fin_status = ST_STUCK_LOW;
                    end
                end
            end
        endcase

        status_next  = status_reg;
        reading_next = reading_reg;
        if (fin)
        begin
            phase_next   = PH_IDLE;
            cnt_next     = '0;
            status_next  = fin_status;
            reading_next = fin_reading;
        end
    end

    // Result fields show the state after this tick
    always_comb
    begin
        res_next.drive_low = (phase_next == PH_START);
        res_next.busy_res  = (phase_next != PH_IDLE);
        res_next.done_res  = fin;
        res_next.status    = status_next;
        res_next.reading   = reading_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= '0;
            bit_reg     <= '0;
            frame_reg   <= '0;
            status_reg  <= ST_OK;
            reading_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            bit_reg     <= bit_next;
            frame_reg   <= frame_next;
            status_reg  <= status_next;
            reading_reg <= reading_next;
        end
    end

    a_drive_in_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        res_next.drive_low |-> res_next.busy_res)
        else $error("line driven low outside a transfer");

    a_done_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_next.done_res |-> !res_next.busy_res)
        else $error("transfer ended but block still busy");

    a_bit_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= BIT_W'(FRAME_BITS))
        else $error("bit index ran past the frame");

    a_status_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !res_next.done_res |=> $stable(status_reg) && $stable(reading_reg))
        else $error("status changed without a transfer ending");

    a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && phase_reg == PH_IDLE && !start_request |=> phase_reg == PH_IDLE)
        else $error("left idle without a start request");

endmodule

>>> design/single_wire_sensor_reader.sv
// Top level of the single-wire sensor reader: channels, config and result register.
//
//  channel  modport  width          transaction
//  -------  -------  -------------  ------------------------------------------
//  tick     sink     1 + 1          one microsecond tick: start_request, line_level
//  result   source   1+1+1+2+32     state after the tick: drive_low .. reading
//  cfg      sink     8 idx, 16 dat  write of one timing register
//
//  One tick transaction is taken per cycle while tick.ready is high; its result
//  appears in the result register on the next cycle, computed by the single
//  state-update pass of swsr_core.
//  Reset (rst_n low, asynchronous) returns to idle, clears status and reading
//  and loads the default timing registers. A stalled result holds in the
//  register; tick.ready drops only while it is full and not being taken.
//  cfg is always ready; write it only while no tick transaction is in flight.
module single_wire_sensor_reader
    import swsr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    swsr_tick_if.sink     tick,
    swsr_result_if.source result,
    swsr_cfg_if.sink      cfg
);

    logic                                step_en;
    logic [NUM_CFG-1:0][COUNT_WIDTH-1:0] limit;
    result_t                             res_next;
    result_t                             res_reg;
    logic                                out_valid_reg;

    // Take a new tick whenever the result register is empty or draining
    assign tick.ready = !out_valid_reg || result.ready;
    assign step_en    = tick.valid && tick.ready;
    assign cfg.ready  = 1'b1;

    swsr_cfg #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .limit    (limit)
    );

    swsr_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (step_en),
        .start_request (tick.start_request),
        .line_level    (tick.line_level),
        .limit         (limit),
        .res_next      (res_next)
    );

    // Result register: load on every accepted tick, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_en)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            res_reg <= res_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.drive_low = res_reg.drive_low;
    assign result.busy_res  = res_reg.busy_res;
    assign result.done_res  = res_reg.done_res;
    assign result.status    = res_reg.status;
    assign result.reading   = res_reg.reading;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |-> !step_en)
        else $error("result overwritten while stalled");

    a_result_follows_tick: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_valid_reg)
        else $error("accepted tick produced no result");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(res_reg))
        else $error("stalled result changed");

endmodule
